[hw/rtl/mets_pkg.sv]
// ----------------------------------------------------------------------------
// mets_pkg
// Shared types, constants and helpers for the escape-time pixel unit.
// ----------------------------------------------------------------------------
package mets_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int OUT_FRAC   = 26;
  localparam int IDX_W      = 12;
  localparam int IT_W       = 11;
  localparam int MAG_W      = 32;
  localparam int Z_W        = MAG_W + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int MUL_CNT_W  = $clog2(MAG_W);
  localparam int ADDR_W     = 5;

  localparam logic [IT_W-1:0] MAX_ITER_LIMIT = IT_W'(1024);
  localparam logic [36:0]     FOUR_Q         = 37'(4) << FRAC_BITS;
  localparam logic signed [Z_W-1:0] Z_BOUND  = {1'b0, {MAG_W{1'b1}}};

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [IT_W-1:0]    max_iter;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
    logic [IT_W-1:0]  count;
    logic             escaped;
    logic [MAG_W-1:0] mag_sq;
  } result_t;

  function automatic logic signed [Z_W-1:0] clamp_z(input logic signed [38:0] v);
    logic signed [38:0] hi;
    logic signed [38:0] lo;
    hi = 39'(Z_BOUND);
    lo = -hi;
    if (v > hi) begin
      return Z_BOUND;
    end else if (v < lo) begin
      return -Z_BOUND;
    end
    return v[Z_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] abs_z(input logic signed [Z_W-1:0] v);
    logic signed [Z_W-1:0] n;
    n = -v;
    return v[Z_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

[hw/rtl/mandelbrot_escape_time_pixel_top.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time pixel unit with stream ports and APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per pixel, tdata = {row, column}.
//   out_* : one transaction per pixel; tdata = column, row, iteration count,
//           |z|^2 (Q6.26, saturating), from bit 0 up; tuser = escaped.
//   cfg_* : origins, steps and iteration limit at byte addresses 0,4,..,16.
// Sequence: the pixel is first mapped on the serial multipliers; each iteration
//   then loads, steps through the 32 multiplier bits and evaluates, and a final
//   pass evaluates the exit before the result is handed off. One pixel is in
//   work at a time.
// A finished result moves into the output register, so the next pixel is
//   accepted while it waits. If out_tready stays low and a second result is
//   ready, the core holds it and in_tready stays low.
// Reset: registers take their default view, the pipeline empties.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // column, pixel_row
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [71:0]                   out_tdata,  // out_column, out_row,
                                                    // iteration_count,
                                                    // magnitude_squared
  output logic                          out_tuser,  // escaped
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mets_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import mets_pkg::*;

  cfg_t     cfg_r;
  logic     out_valid_r;
  result_t  out_r;
  logic     idle;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     wr;
  reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign widx       = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin <= -32'sd536870912;
      cfg_r.y_origin <= -32'sd402653184;
      cfg_r.x_step   <= 31'd786432;
      cfg_r.y_step   <= 31'd786432;
      cfg_r.max_iter <= IT_W'(256);
    end else if (wr) begin
      case (widx)
        REG_X_ORIGIN: cfg_r.x_origin <= cfg_pwdata;
        REG_Y_ORIGIN: cfg_r.y_origin <= cfg_pwdata;
        REG_X_STEP:   cfg_r.x_step   <= cfg_pwdata[30:0];
        REG_Y_STEP:   cfg_r.y_step   <= cfg_pwdata[30:0];
        REG_MAX_ITER: cfg_r.max_iter <= cfg_pwdata[IT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_X_ORIGIN: cfg_prdata = cfg_r.x_origin;
      REG_Y_ORIGIN: cfg_prdata = cfg_r.y_origin;
      REG_X_STEP:   cfg_prdata = {1'b0, cfg_r.x_step};
      REG_Y_STEP:   cfg_prdata = {1'b0, cfg_r.y_step};
      REG_MAX_ITER: cfg_prdata = {{(32-IT_W){1'b0}}, cfg_r.max_iter};
      default:      cfg_prdata = '0;
    endcase
  end

  assign in_tready = idle;

  mets_core u_core (
    .clk,
    .rst_n,
    .cfg       (cfg_r),
    .start     (in_tvalid & idle),
    .column    (in_tdata[11:0]),
    .row       (in_tdata[23:12]),
    .idle,
    .res_valid,
    .res_ready,
    .res
  );

  assign res_ready = res_valid & (~out_valid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.mag_sq, out_r.count, out_r.row, out_r.column};
  assign out_tuser  = out_r.escaped;

endmodule

[hw/rtl/mets_smul.sv]
// ----------------------------------------------------------------------------
// mets_smul
// Bit-serial unsigned 32x32 multiplier, one multiplier bit per cycle while step is high.
// ----------------------------------------------------------------------------
module mets_smul (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [mets_pkg::MAG_W-1:0]  a,
  input  logic [mets_pkg::MAG_W-1:0]  b,
  output logic [mets_pkg::PROD_W-1:0] prod
);
  import mets_pkg::*;

  logic [MAG_W-1:0]  a_r;
  logic [PROD_W-1:0] acc_r;
  logic [MAG_W:0]    hi_sum;

  always_comb begin
    hi_sum = {1'b0, acc_r[PROD_W-1:MAG_W]} + (acc_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= a;
      acc_r <= {{MAG_W{1'b0}}, b};
    end else if (step) begin
      acc_r <= {hi_sum, acc_r[MAG_W-1:1]};
    end
  end

  assign prod = acc_r;

endmodule

[hw/rtl/mets_core.sv]
// ----------------------------------------------------------------------------
// mets_core
// Point mapping and z = z*z + c iteration over three serial multipliers.
// ----------------------------------------------------------------------------
module mets_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mets_pkg::cfg_t                cfg,
  input  logic                          start,
  input  logic [mets_pkg::IDX_W-1:0]    column,
  input  logic [mets_pkg::IDX_W-1:0]    row,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mets_pkg::result_t             res
);
  import mets_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_MAPFIN, S_LOADM, S_MUL, S_EVAL, S_DONE
  } state_t;

  state_t                 state_r;
  logic [MUL_CNT_W-1:0]   cnt_r;
  logic [IT_W-1:0]        it_r;
  logic [IT_W-1:0]        lim_r;
  logic [IDX_W-1:0]       col_r;
  logic [IDX_W-1:0]       row_r;
  logic signed [31:0]     cx_r;
  logic signed [31:0]     cy_r;
  logic signed [Z_W-1:0]  x_r;
  logic signed [Z_W-1:0]  y_r;
  logic                   esc_r;
  logic [MAG_W-1:0]       mag_r;

  logic                   mload;
  logic                   mstep;
  logic [MAG_W-1:0]       ax, ay;
  logic [MAG_W-1:0]       a0, b0, a1, b1;
  logic [PROD_W-1:0]      p0, p1, p2;
  logic signed [44:0]     mx, my;
  logic [35:0]            sx, sy;
  logic [36:0]            sum;
  logic [36:0]            pm;
  logic signed [37:0]     sp;
  logic signed [38:0]     nx, ny;
  logic                   stop;

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    if (v > 45'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -45'sh80000000) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    ax    = abs_z(x_r);
    ay    = abs_z(y_r);
    mload = (state_r == S_IDLE && start) || state_r == S_LOADM;
    mstep = state_r == S_MAP || state_r == S_MUL;
    if (state_r == S_IDLE) begin
      a0 = {1'b0, cfg.x_step};
      b0 = {{(MAG_W-IDX_W){1'b0}}, column};
      a1 = {1'b0, cfg.y_step};
      b1 = {{(MAG_W-IDX_W){1'b0}}, row};
    end else begin
      a0 = ax;
      b0 = ax;
      a1 = ay;
      b1 = ay;
    end
    mx   = {{13{cfg.x_origin[31]}}, cfg.x_origin} + $signed({1'b0, p0[43:0]});
    my   = {{13{cfg.y_origin[31]}}, cfg.y_origin} + $signed({1'b0, p1[43:0]});
    sx   = p0[PROD_W-1:FRAC_BITS];
    sy   = p1[PROD_W-1:FRAC_BITS];
    sum  = {1'b0, sx} + {1'b0, sy};
    pm   = p2[PROD_W-1:FRAC_BITS-1];
    sp   = (x_r[Z_W-1] ^ y_r[Z_W-1]) ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
    nx   = $signed({3'b000, sx}) - $signed({3'b000, sy}) + {{7{cx_r[31]}}, cx_r};
    ny   = {sp[37], sp} + {{7{cy_r[31]}}, cy_r};
    stop = (it_r >= lim_r) || (sum > FOUR_Q);
  end

  mets_smul u_mul_xx (.clk, .load(mload), .step(mstep), .a(a0), .b(b0), .prod(p0));
  mets_smul u_mul_yy (.clk, .load(mload), .step(mstep), .a(a1), .b(b1), .prod(p1));
  mets_smul u_mul_xy (.clk, .load(mload), .step(mstep), .a(ax), .b(ay), .prod(p2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      it_r    <= '0;
      lim_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            col_r   <= column;
            row_r   <= row;
            lim_r   <= (cfg.max_iter > MAX_ITER_LIMIT) ? MAX_ITER_LIMIT : cfg.max_iter;
            cnt_r   <= '0;
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r) begin
            state_r <= S_MAPFIN;
          end
        end
        S_MAPFIN: begin
          cx_r    <= sat32(mx);
          cy_r    <= sat32(my);
          x_r     <= '0;
          y_r     <= '0;
          it_r    <= '0;
          state_r <= S_LOADM;
        end
        S_LOADM: begin
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (stop) begin
            esc_r   <= it_r < lim_r;
            mag_r   <= (|sum[36:34]) ? '1 : sum[33:2];
            state_r <= S_DONE;
          end else begin
            x_r     <= clamp_z(nx);
            y_r     <= clamp_z(ny);
            it_r    <= it_r + 1'b1;
            state_r <= S_LOADM;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle      = state_r == S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res       = '{column: col_r, row: row_r, count: it_r, escaped: esc_r, mag_sq: mag_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL || state_r == S_DONE) |-> it_r <= lim_r)
    else $error("iteration count above limit");

  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && esc_r) |-> it_r < lim_r)
    else $error("escaped flag with count at limit");

  a_eval_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |=> (state_r == S_LOADM || state_r == S_DONE))
    else $error("bad state after evaluation");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_MAP && cnt_r == '0)
    else $error("start not taken");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel transactions into the escape-time unit across several register
// settings, predicts every result and checks it field by field, in order.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
  longint x_origin, y_origin, x_step, y_step, max_iter;
  mets_pkg::result_t expected_pixels[$];
  int errors;

  function new();
    x_origin = -536870912;
    y_origin = -402653184;
    x_step   = 786432;
    y_step   = 786432;
    max_iter = 256;
    errors   = 0;
  endfunction

  function void set_reg(mets_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      mets_pkg::REG_X_ORIGIN: x_origin = longint'(signed'(v));
      mets_pkg::REG_Y_ORIGIN: y_origin = longint'(signed'(v));
      mets_pkg::REG_X_STEP:   x_step   = longint'(v[30:0]);
      mets_pkg::REG_Y_STEP:   y_step   = longint'(v[30:0]);
      default:                max_iter = longint'(v[10:0]);
    endcase
  endfunction

  function longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint clamp(longint v);
    if (v > 64'sd4294967295) return 64'sd4294967295;
    if (v < -64'sd4294967295) return -64'sd4294967295;
    return v;
  endfunction

  function longint unsigned absv(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function longint unsigned sq(longint v);
    return (absv(v) * absv(v)) >> mets_pkg::FRAC_BITS;
  endfunction

  function void note_pixel(logic [11:0] col, logic [11:0] row);
    longint cx, cy, x, y, nx, ny, lim, it;
    longint unsigned sx, sy, m, mag;
    mets_pkg::result_t e;
    cx  = sat32(x_origin + x_step * longint'(col));
    cy  = sat32(y_origin + y_step * longint'(row));
    lim = (max_iter > 1024) ? 1024 : max_iter;
    x = 0;
    y = 0;
    it = 0;
    while (it < lim) begin
      sx = sq(x);
      sy = sq(y);
      if (sx + sy > (64'd4 << mets_pkg::FRAC_BITS)) break;
      nx = longint'(sx) - longint'(sy) + cx;
      m  = (absv(x) * absv(y)) >> (mets_pkg::FRAC_BITS - 1);
      ny = (((x < 0) != (y < 0)) ? -longint'(m) : longint'(m)) + cy;
      x  = clamp(nx);
      y  = clamp(ny);
      it++;
    end
    mag = (sq(x) + sq(y)) >> (mets_pkg::FRAC_BITS - mets_pkg::OUT_FRAC);
    e.column  = col;
    e.row     = row;
    e.count   = it[10:0];
    e.escaped = (it < lim);
    e.mag_sq  = (mag > 64'hFFFFFFFF) ? 32'hFFFFFFFF : mag[31:0];
    expected_pixels.push_back(e);
  endfunction

  function void check_result(mets_pkg::result_t a);
    mets_pkg::result_t e;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected result col=%0d row=%0d", $time, a.column, a.row);
      errors++;
      return;
    end
    e = expected_pixels.pop_front();
    if (a.column !== e.column) begin
      $display("%0t: column exp %0d got %0d", $time, e.column, a.column);
      errors++;
    end
    if (a.row !== e.row) begin
      $display("%0t: row exp %0d got %0d", $time, e.row, a.row);
      errors++;
    end
    if (a.count !== e.count) begin
      $display("%0t: count exp %0d got %0d", $time, e.count, a.count);
      errors++;
    end
    if (a.escaped !== e.escaped) begin
      $display("%0t: escaped exp %0b got %0b", $time, e.escaped, a.escaped);
      errors++;
    end
    if (a.mag_sq !== e.mag_sq) begin
      $display("%0t: |z|^2 exp %h got %h", $time, e.mag_sq, a.mag_sq);
      errors++;
    end
  endfunction
endclass

module testbench;
  import mets_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  pixel_scoreboard sb;
  int  burst_left;
  bit  hold_req;
  int  pat_mode;

  mandelbrot_escape_time_pixel_top u_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.column  = out_tdata[11:0];
      r.row     = out_tdata[23:12];
      r.count   = out_tdata[34:24];
      r.mag_sq  = out_tdata[66:35];
      r.escaped = out_tuser;
      sb.check_result(r);
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int n;
    out_tready = 0;
    n = 0;
    pat_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end
      if (n == 0) begin
        n = $urandom_range(50, 400);
        pat_mode = $urandom_range(0, 2);
      end
      n--;
      case (pat_mode)
        0: out_tready = 1;
        1: out_tready = $urandom_range(0, 1);
        default: out_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
    cfg_psel    = 1;
    cfg_pwrite  = 1;
    cfg_penable = 0;
    cfg_paddr   = ADDR_W'({idx, 2'b00});
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_psel    = 0;
    cfg_penable = 0;
    cfg_pwrite  = 0;
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    if (burst_left == 0) begin
      in_tvalid = 0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid = 1;
    in_tdata  = {row, col};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(col, row);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_all(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                         logic [31:0] ys, logic [31:0] lim);
    cfg_write(REG_X_ORIGIN, xo);
    cfg_write(REG_Y_ORIGIN, yo);
    cfg_write(REG_X_STEP, xs);
    cfg_write(REG_Y_STEP, ys);
    cfg_write(REG_MAX_ITER, lim);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_req = 0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // reset view: corners and two inner points
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd682, 12'd512);
    send_pixel(12'd2730, 12'd1365);
    drain();

    // limit of zero
    set_all(32'h0, 32'h0, 32'd1000, 32'd1000, 32'd0);
    send_pixel(12'd5, 12'd7);
    send_pixel(12'd4095, 12'd4095);
    drain();
    // limit above maximum, origin inside the set
    set_all(32'h0, 32'h0, 32'd0, 32'd0, 32'd2047);
    send_pixel(12'd1, 12'd1);
    drain();
    // limit of one and exactly the maximum
    cfg_write(REG_MAX_ITER, 32'd1);
    send_pixel(12'd0, 12'd0);
    drain();
    cfg_write(REG_MAX_ITER, 32'd1024);
    cfg_write(REG_X_ORIGIN, 32'hF8000000);
    send_pixel(12'd0, 12'd0);
    drain();
    // point saturation and magnitude saturation, both signs
    set_all(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'd20);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    drain();
    set_all(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'd3);
    send_pixel(12'd0, 12'd0);
    drain();
    set_all(32'h40000000, 32'h20000000, 32'h00100000, 32'h00100000, 32'd8);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd100, 12'd200);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      logic [31:0] xo, yo, xs, ys, lim;
      if (ph == 8) begin
        xo = $urandom();
        yo = $urandom();
        xs = $urandom();
        ys = $urandom();
      end else begin
        xo = $urandom_range(0, 32'd805306368) - 32'd671088640;
        yo = $urandom_range(0, 32'd536870912) - 32'd402653184;
        xs = $urandom_range(1, 32'h00040000) | ($urandom_range(0, 1) << 31);
        ys = $urandom_range(1, 32'h00040000);
      end
      lim = (ph == 2) ? 32'd1 : (ph == 5) ? 32'd48 : $urandom_range(2, 24);
      if (ph == 7) lim = lim | 32'hFFFFF800 & ~32'h7FF;
      set_all(xo, yo, xs, ys, lim);
      if (ph == 2) hold_req = 1;
      repeat (200) send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      drain();
    end

    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/mets_pkg.sv
hw/rtl/mets_smul.sv
hw/rtl/mets_core.sv
hw/rtl/mandelbrot_escape_time_pixel_top.sv
sim/testbench.sv
